@@ rtl/pbfl_pkg.sv @@
package pbfl_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ID_W   = 48;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned PIDX_W = 16;
  localparam int unsigned SIZE_W = 31;
  localparam int unsigned CIDX_W = 2;

  // Divider geometry: a 48-bit dividend over a 31-bit divisor.
  localparam int unsigned DIV_W  = 48;
  localparam int unsigned DVS_W  = 31;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNINIT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_SHORT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_DBL_FREE = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVER_CAP = 3'd5;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_PAGE_INDEX  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PAGE_BYTES  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BLOCK_BYTES = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/pbfl_div.sv @@
// Restoring divider, one quotient bit per cycle. The quotient is valid from
// the done pulse until the next start.
module pbfl_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbfl_pkg::div_req_t  req_i,
  output pbfl_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned CNT_BITS = $clog2(pbfl_pkg::DIV_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_BITS-1:0]         cnt_q, cnt_d;
  logic [pbfl_pkg::DIV_W-1:0]  quo_q, quo_d;
  logic [pbfl_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [pbfl_pkg::DVS_W-1:0]  dsr_q, dsr_d;

  logic [pbfl_pkg::DVS_W:0]    trial;
  logic [pbfl_pkg::DVS_W+1:0]  diff;

  assign trial = {rem_q, quo_q[pbfl_pkg::DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits DVS_W bits.
      if (!diff[pbfl_pkg::DVS_W+1]) begin
        rem_d = diff[pbfl_pkg::DVS_W-1:0];
        quo_d = {quo_q[pbfl_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[pbfl_pkg::DVS_W-1:0];
        quo_d = {quo_q[pbfl_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(pbfl_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/page_block_free_list_allocator.sv @@
// Page block free-list allocator. Commands are issued with start while busy
// is low; every command produces one or more result words, each shown for
// exactly one cycle with valid_o high, the final one flagged by last_o, and
// the receiver cannot stall them. Clear, and any command refused at once
// (uninitialised, short alloc, out-of-range free, zero block size), answers
// in the cycle after acceptance without raising busy. An alloc of n ids
// streams its n words back to back, one stack read per cycle. A free
// searches the stack one entry per cycle through its single registered read
// port before the push. An init does one multiply, then two 48-bit divisions
// on a shared bit-per-cycle divider (first block rounded up, end block
// rounded down), then one stack write per cycle to fill the ids in ascending
// order. Configuration writes are taken at any edge with cfg_we_i high and
// must only be issued while the block is idle.
module page_block_free_list_allocator #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [pbfl_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [pbfl_pkg::SIZE_W-1:0]    cfg_wdata_i,
  // Command side.
  input  logic                           start,
  output logic                           busy,
  input  logic [pbfl_pkg::FUNC_W-1:0]    func_i,
  input  logic [pbfl_pkg::CNT_W-1:0]     count_i,
  input  logic [pbfl_pkg::ID_W-1:0]      block_id_i,
  // Result side.
  output logic                           valid_o,
  output logic [pbfl_pkg::ID_W-1:0]      out_block_o,
  output logic                           block_valid_o,
  output logic [pbfl_pkg::STAT_W-1:0]    status_o,
  output logic [pbfl_pkg::CNT_W-1:0]     free_count_o,
  output logic                           is_full_o,
  output logic                           is_empty_o,
  output logic                           last_o
);

  // Stack address width and depth counter width.
  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_DLO_GO   = 4'd2;
  localparam logic [3:0] S_DLO_WAIT = 4'd3;
  localparam logic [3:0] S_DHI_GO   = 4'd4;
  localparam logic [3:0] S_DHI_WAIT = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd6;
  localparam logic [3:0] S_FILL     = 4'd7;
  localparam logic [3:0] S_ALLOC    = 4'd8;
  localparam logic [3:0] S_DRAIN    = 4'd9;
  localparam logic [3:0] S_SCAN     = 4'd10;
  localparam logic [3:0] S_PUSH     = 4'd11;

  // Configuration registers.
  logic [pbfl_pkg::PIDX_W-1:0] page_index_q;
  logic [pbfl_pkg::SIZE_W-1:0] page_bytes_q;
  logic [pbfl_pkg::SIZE_W-1:0] block_bytes_q;

  // Sequencer and allocator state.
  logic [3:0]                  state_q, state_d;
  logic [CW-1:0]               depth_q, depth_d;
  logic [CW-1:0]               total_q, total_d;
  logic [pbfl_pkg::ID_W-1:0]   first_q, first_d;
  logic [pbfl_pkg::ID_W-1:0]   end_q, end_d;
  logic [pbfl_pkg::ID_W-1:0]   lo_q, lo_d;
  logic [pbfl_pkg::ID_W-1:0]   hi_q, hi_d;
  logic [pbfl_pkg::DIV_W-1:0]  prod_q, prod_d;
  logic [pbfl_pkg::ID_W-1:0]   id_q, id_d;
  logic [AW-1:0]               ptr_q, ptr_d;
  logic [CW-1:0]               left_q, left_d;
  logic [CW-1:0]               scan_q, scan_d;
  logic [CW-1:0]               fill_q, fill_d;
  logic                        pend_q, pend_d;
  logic                        pend_last_q, pend_last_d;

  // Free stack memory: one write and one registered read per cycle.
  logic [pbfl_pkg::ID_W-1:0]   stack_mem [MAX_BLOCKS];
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [pbfl_pkg::ID_W-1:0]   mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [pbfl_pkg::ID_W-1:0]   mem_rdata_q;

  // Result word being assembled for the output register.
  logic                        emit_d;
  logic [pbfl_pkg::ID_W-1:0]   res_block_d;
  logic                        res_bv_d;
  logic [pbfl_pkg::STAT_W-1:0] res_status_d;
  logic                        res_last_d;
  logic                        res_init;

  logic                        valid_q;
  logic [pbfl_pkg::ID_W-1:0]   out_block_q;
  logic                        block_valid_q;
  logic [pbfl_pkg::STAT_W-1:0] status_q;
  logic [pbfl_pkg::CNT_W-1:0]  free_count_q;
  logic                        is_full_q;
  logic                        is_empty_q;
  logic                        last_q;

  // Shared divider.
  pbfl_pkg::div_req_t          div_req;
  pbfl_pkg::div_rsp_t          div_rsp;

  logic [pbfl_pkg::DIV_W-2:0]  mul_full;
  logic [pbfl_pkg::ID_W:0]     range_diff;
  logic                        accept;

  assign accept     = start && !busy;
  assign mul_full   = page_index_q * page_bytes_q;
  assign range_diff = {1'b0, hi_q} - {1'b0, lo_q};

  pbfl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    total_d      = total_q;
    first_d      = first_q;
    end_d        = end_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    prod_d       = prod_q;
    id_d         = id_q;
    ptr_d        = ptr_q;
    left_d       = left_q;
    scan_d       = scan_q;
    fill_d       = fill_q;
    pend_d       = 1'b0;
    pend_last_d  = pend_last_q;

    mem_we       = 1'b0;
    mem_waddr    = depth_q[AW-1:0];
    mem_wdata    = id_q;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q;

    div_req.start    = 1'b0;
    div_req.dividend = pbfl_pkg::DIV_W'(prod_q + pbfl_pkg::DIV_W'(block_bytes_q)
                                        - pbfl_pkg::DIV_W'(1));
    div_req.divisor  = block_bytes_q;

    emit_d       = 1'b0;
    res_block_d  = '0;
    res_bv_d     = 1'b0;
    res_status_d = pbfl_pkg::ST_OK;
    res_last_d   = 1'b1;

    // A stack read issued in the previous cycle delivers one allocated id.
    if (pend_q && (state_q == S_ALLOC || state_q == S_DRAIN)) begin
      emit_d      = 1'b1;
      res_block_d = mem_rdata_q;
      res_bv_d    = 1'b1;
      res_last_d  = pend_last_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func_i)
            pbfl_pkg::FUNC_ALLOC: begin
              if (total_q == '0) begin
                emit_d       = 1'b1;
                res_status_d = pbfl_pkg::ST_UNINIT;
              end else if (depth_q == '0 || count_i > pbfl_pkg::CNT_W'(depth_q)) begin
                emit_d       = 1'b1;
                res_status_d = pbfl_pkg::ST_SHORT;
              end else if (count_i == '0) begin
                emit_d       = 1'b1;
              end else begin
                // Every word of the burst reports the depth left afterwards.
                depth_d = depth_q - CW'(count_i);
                ptr_d   = AW'(depth_q - CW'(1));
                left_d  = CW'(count_i);
                state_d = S_ALLOC;
              end
            end
            pbfl_pkg::FUNC_FREE: begin
              id_d = block_id_i;
              if (total_q == '0) begin
                emit_d       = 1'b1;
                res_status_d = pbfl_pkg::ST_UNINIT;
              end else if (block_id_i < first_q || block_id_i >= end_q) begin
                emit_d       = 1'b1;
                res_status_d = pbfl_pkg::ST_RANGE;
              end else if (depth_q == '0) begin
                state_d = S_PUSH;
              end else begin
                scan_d  = '0;
                state_d = S_SCAN;
              end
            end
            pbfl_pkg::FUNC_INIT: begin
              // Init always starts from a cleared allocator.
              depth_d = '0;
              total_d = '0;
              first_d = '0;
              end_d   = '0;
              if (block_bytes_q == '0) begin
                emit_d       = 1'b1;
                res_status_d = pbfl_pkg::ST_RANGE;
              end else begin
                state_d = S_MUL;
              end
            end
            pbfl_pkg::FUNC_CLEAR: begin
              depth_d = '0;
              total_d = '0;
              first_d = '0;
              end_d   = '0;
              emit_d  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        prod_d  = {1'b0, mul_full};
        state_d = S_DLO_GO;
      end
      S_DLO_GO: begin
        // First block: rounded-up quotient.
        div_req.start = 1'b1;
        state_d       = S_DLO_WAIT;
      end
      S_DLO_WAIT: begin
        if (div_rsp.done) begin
          lo_d    = div_rsp.quotient;
          state_d = S_DHI_GO;
        end
      end
      S_DHI_GO: begin
        // End block: rounded-down quotient of the next page's start.
        div_req.start    = 1'b1;
        div_req.dividend = pbfl_pkg::DIV_W'(prod_q + pbfl_pkg::DIV_W'(page_bytes_q));
        state_d          = S_DHI_WAIT;
      end
      S_DHI_WAIT: begin
        if (div_rsp.done) begin
          hi_d    = div_rsp.quotient;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (range_diff[pbfl_pkg::ID_W] || range_diff == '0) begin
          emit_d       = 1'b1;
          res_status_d = pbfl_pkg::ST_UNINIT;
          state_d      = S_IDLE;
        end else if (range_diff[pbfl_pkg::ID_W-1:0] > pbfl_pkg::ID_W'(MAX_BLOCKS)) begin
          emit_d       = 1'b1;
          res_status_d = pbfl_pkg::ST_OVER_CAP;
          state_d      = S_IDLE;
        end else begin
          first_d = lo_q;
          end_d   = hi_q;
          total_d = CW'(range_diff);
          fill_d  = '0;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_q[AW-1:0];
        mem_wdata = pbfl_pkg::ID_W'(lo_q + pbfl_pkg::ID_W'(fill_q));
        fill_d    = fill_q + CW'(1);
        if (fill_q == total_q - CW'(1)) begin
          depth_d = total_q;
          emit_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ALLOC: begin
        mem_re      = 1'b1;
        mem_raddr   = ptr_q;
        ptr_d       = ptr_q - AW'(1);
        left_d      = left_q - CW'(1);
        pend_d      = 1'b1;
        pend_last_d = (left_q == CW'(1));
        if (left_q == CW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (pend_q && mem_rdata_q == id_q) begin
          emit_d       = 1'b1;
          res_status_d = pbfl_pkg::ST_DBL_FREE;
          state_d      = S_IDLE;
        end else if (pend_q && pend_last_q) begin
          state_d = S_PUSH;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = scan_q[AW-1:0];
          scan_d      = scan_q + CW'(1);
          pend_d      = 1'b1;
          pend_last_d = (scan_q == depth_q - CW'(1));
        end
      end
      S_PUSH: begin
        emit_d  = 1'b1;
        state_d = S_IDLE;
        if (depth_q >= CW'(MAX_BLOCKS)) begin
          res_status_d = pbfl_pkg::ST_OVER_CAP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = depth_q[AW-1:0];
          mem_wdata = id_q;
          depth_d   = depth_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Status fields always describe the state after the command.
  assign res_init = (total_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_index_q  <= '0;
      page_bytes_q  <= pbfl_pkg::SIZE_W'(2097152);
      block_bytes_q <= pbfl_pkg::SIZE_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbfl_pkg::CFG_PAGE_INDEX:  page_index_q  <= cfg_wdata_i[pbfl_pkg::PIDX_W-1:0];
        pbfl_pkg::CFG_PAGE_BYTES:  page_bytes_q  <= cfg_wdata_i;
        pbfl_pkg::CFG_BLOCK_BYTES: block_bytes_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      total_q <= '0;
      first_q <= '0;
      end_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      total_q <= total_d;
      first_q <= first_d;
      end_q   <= end_d;
      pend_q  <= pend_d;
      valid_q <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    prod_q        <= prod_d;
    id_q          <= id_d;
    ptr_q         <= ptr_d;
    left_q        <= left_d;
    scan_q        <= scan_d;
    fill_q        <= fill_d;
    pend_last_q   <= pend_last_d;
    out_block_q   <= res_block_d;
    block_valid_q <= res_bv_d;
    status_q      <= res_status_d;
    last_q        <= res_last_d;
    free_count_q  <= res_init ? pbfl_pkg::CNT_W'(depth_d) : '0;
    is_full_q     <= res_init && (depth_d == '0);
    is_empty_q    <= res_init && (depth_d == total_d);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= stack_mem[mem_raddr];
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign out_block_o   = out_block_q;
  assign block_valid_o = block_valid_q;
  assign status_o      = status_q;
  assign free_count_o  = free_count_q;
  assign is_full_o     = is_full_q;
  assign is_empty_o    = is_empty_q;
  assign last_o        = last_q;

  // The stack never holds more ids than the page has blocks.
  a_depth_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= total_q)
    else $error("free stack deeper than the page block count");

  // An alloc burst streams its words in consecutive cycles.
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("gap inside a multi-word alloc burst");

  // Non-final words only occur while the command is still in progress.
  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("non-final word shown while the block is idle");

  // A push only happens when some block of the page is not yet free.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH |-> depth_q < total_q)
    else $error("push reached with every block already free");

endmodule
